FILE: hw/rtl/rtil_pkg.sv
// types and codes shared by the route and interface lookup block
package rtil_pkg;

    typedef enum logic [1:0] {
        CMD_LOOKUP   = 2'd0,
        CMD_ROUTE_WR = 2'd1,
        CMD_IF_WR    = 2'd2
    } t_cmd_code;

    typedef enum logic [2:0] {
        CFG_IF_COUNT  = 3'd0,
        CFG_DEF_EN    = 3'd1,
        CFG_DEF_INDEX = 3'd2,
        CFG_RX_IF     = 3'd3,
        CFG_MCAST     = 3'd4
    } t_cfg_index;

    localparam logic [31:0] MCAST_RESET      = 32'hE000_0009;
    localparam logic [4:0]  COST_UNREACHABLE = 5'd16;

    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  entry_index;
        logic [31:0] address;
        logic [31:0] mask;
        logic [31:0] hop_addr;
        logic [4:0]  cost;
        logic        directly_connected;
        logic [2:0]  route_interface;
        logic        entry_valid;
    } t_cmd;

    typedef struct packed {
        logic       route_found;
        logic [5:0] out_index;
    } t_rsp;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] value;
    } t_cfg;

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] hop;
        logic        valid;
        logic [4:0]  cost;
        logic        direct;
        logic [2:0]  iface;
    } t_route_word;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] mask;
    } t_if_word;

endpackage

FILE: hw/rtl/rtil_if.sv
// handshake channels for commands, results and configuration writes
interface rtil_cmd_if;
    logic           valid;
    logic           ready;
    rtil_pkg::t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rtil_rsp_if;
    logic           valid;
    logic           ready;
    rtil_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rtil_cfg_if;
    logic           valid;
    logic           ready;
    rtil_pkg::t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/rtil_ram.sv
// generic single write port ram with registered read
module rtil_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/route_table_interface_lookup_unit.sv
// route table and interface table lookup, one route or interface entry checked per cycle
// flow: writes stay idle; a multicast lookup goes straight to the done state; others scan the
// route table, scan the interfaces for the hop of a hit, read the default entry (request and
// check states) on a miss, scan the interfaces for its hop unless direct (two scans at most), then load
// throughput: one lookup at a time, next command accepted the cycle after the result is loaded
// reset: synchronous active low; clears valid bits, config registers and the sequencer
module route_table_interface_lookup_unit #(
    parameter int ROUTE_ENTRIES     = 64,
    parameter int INTERFACE_ENTRIES = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rtil_cmd_if.sink  i_cmd,
    rtil_rsp_if.source o_rsp,
    rtil_cfg_if.sink  i_cfg
);

    localparam int RT_DEPTH = (ROUTE_ENTRIES < 64) ? ROUTE_ENTRIES : 64;
    localparam int RT_AW    = (RT_DEPTH > 1) ? $clog2(RT_DEPTH) : 1;
    localparam int IF_DEPTH = INTERFACE_ENTRIES;
    localparam int IF_AW    = (IF_DEPTH > 1) ? $clog2(IF_DEPTH) : 1;
    localparam int LW       = ($clog2(IF_DEPTH + 1) > 4) ? $clog2(IF_DEPTH + 1) : 4;
    localparam int RT_W     = $bits(rtil_pkg::t_route_word);
    localparam int IF_W     = $bits(rtil_pkg::t_if_word);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_RSCAN = 6'b000010,
        ST_DREQ  = 6'b000100,
        ST_DCHK  = 6'b001000,
        ST_ISCAN = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [3:0]  r_if_count;
    logic        r_def_en;
    logic [5:0]  r_def_idx;
    logic [2:0]  r_rx_if;
    logic [31:0] r_mcast;

    logic [RT_AW-1:0] r_ridx, n_ridx, r_chk, n_chk;
    logic             r_qv, n_qv;
    logic [IF_AW-1:0] r_iidx, n_iidx, r_ichk, n_ichk;
    logic             r_iqv, n_iqv;
    logic [31:0]      r_addr, n_addr;
    logic [31:0]      r_hop, n_hop;
    logic [2:0]       r_fallback, n_fallback;
    logic             r_in_default, n_in_default;
    logic             r_res_found, n_res_found;
    logic [5:0]       r_res_idx, n_res_idx;
    logic             r_ovalid, n_ovalid;
    logic             r_ofound, n_ofound;
    logic [5:0]       r_oidx, n_oidx;
    logic [RT_DEPTH-1:0] r_written, n_written;

    logic                   w_cmd_acc;
    logic                   w_rt_we;
    logic                   w_if_we;
    logic [RT_AW-1:0]       w_rt_rd_addr;
    rtil_pkg::t_route_word  w_rt_wdata;
    rtil_pkg::t_route_word  w_rt_q;
    rtil_pkg::t_if_word     w_if_wdata;
    rtil_pkg::t_if_word     w_if_q;
    logic [RT_W-1:0]        w_rt_q_raw;
    logic [IF_W-1:0]        w_if_q_raw;
    logic                   w_def_active;
    logic [RT_AW-1:0]       w_def_addr;
    logic [LW-1:0]          w_limit;
    logic                   w_route_hit;
    logic                   w_if_hit;
    logic                   w_if_fail;

    assign w_cmd_acc    = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign o_rsp.valid  = r_ovalid;
    assign o_rsp.data.route_found = r_ofound;
    assign o_rsp.data.out_index   = r_oidx;

    assign w_def_active = r_def_en && (int'(r_def_idx) < ROUTE_ENTRIES);
    assign w_def_addr   = RT_AW'(r_def_idx);
    assign w_limit      = (LW'(r_if_count) > LW'(IF_DEPTH)) ? LW'(IF_DEPTH) : LW'(r_if_count);

    assign w_rt_we = w_cmd_acc && (i_cmd.data.command == rtil_pkg::CMD_ROUTE_WR)
                     && (int'(i_cmd.data.entry_index) < RT_DEPTH);
    assign w_if_we = w_cmd_acc && (i_cmd.data.command == rtil_pkg::CMD_IF_WR)
                     && (int'(i_cmd.data.entry_index) < IF_DEPTH);

    always_comb begin
        w_rt_wdata.dest   = i_cmd.data.address;
        w_rt_wdata.mask   = i_cmd.data.mask;
        w_rt_wdata.hop    = i_cmd.data.hop_addr;
        w_rt_wdata.valid  = i_cmd.data.entry_valid;
        w_rt_wdata.cost   = i_cmd.data.cost;
        w_rt_wdata.direct = i_cmd.data.directly_connected;
        w_rt_wdata.iface  = i_cmd.data.route_interface;
        w_if_wdata.addr   = i_cmd.data.address;
        w_if_wdata.mask   = i_cmd.data.mask;
    end

    assign w_rt_rd_addr = (r_state == ST_DREQ) ? w_def_addr : r_ridx;

    rtil_ram #(.WIDTH(RT_W), .DEPTH(RT_DEPTH), .AW(RT_AW)) u_route_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_rt_we),
        .i_wr_addr (RT_AW'(i_cmd.data.entry_index)),
        .i_wr_data (w_rt_wdata),
        .i_rd_addr (w_rt_rd_addr),
        .o_rd_data (w_rt_q_raw)
    );

    rtil_ram #(.WIDTH(IF_W), .DEPTH(IF_DEPTH), .AW(IF_AW)) u_if_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_if_we),
        .i_wr_addr (IF_AW'(i_cmd.data.entry_index)),
        .i_wr_data (w_if_wdata),
        .i_rd_addr (r_iidx),
        .o_rd_data (w_if_q_raw)
    );

    assign w_rt_q = rtil_pkg::t_route_word'(w_rt_q_raw);
    assign w_if_q = rtil_pkg::t_if_word'(w_if_q_raw);

    // route entry on the read port is usable and matches the destination
    assign w_route_hit = r_qv && r_written[r_chk] && w_rt_q.valid
                         && !(w_def_active && (6'(r_chk) == r_def_idx))
                         && (w_rt_q.dest == (r_addr & w_rt_q.mask))
                         && (w_rt_q.cost != rtil_pkg::COST_UNREACHABLE);

    assign w_if_hit = r_iqv && (LW'(r_ichk) < w_limit)
                      && !(w_def_active && (6'(r_ichk) == r_def_idx))
                      && ((r_hop & w_if_q.mask) == (w_if_q.addr & w_if_q.mask));

    assign w_if_fail = (w_limit == '0)
                       || (r_iqv && !w_if_hit && ((LW'(r_ichk) + LW'(1)) >= w_limit));

    always_comb begin
        n_state      = r_state;
        n_ridx       = r_ridx;
        n_chk        = r_chk;
        n_qv         = r_qv;
        n_iidx       = r_iidx;
        n_ichk       = r_ichk;
        n_iqv        = r_iqv;
        n_addr       = r_addr;
        n_hop        = r_hop;
        n_fallback   = r_fallback;
        n_in_default = r_in_default;
        n_res_found  = r_res_found;
        n_res_idx    = r_res_idx;
        n_ovalid     = r_ovalid;
        n_ofound     = r_ofound;
        n_oidx       = r_oidx;
        n_written    = r_written;

        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end
        if (w_rt_we) begin
            n_written[RT_AW'(i_cmd.data.entry_index)] = 1'b1;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_cmd_acc && (i_cmd.data.command == rtil_pkg::CMD_LOOKUP)) begin
                    n_addr       = i_cmd.data.address;
                    n_in_default = 1'b0;
                    if (i_cmd.data.address == r_mcast) begin
                        n_res_found = 1'b1;
                        n_res_idx   = 6'(r_rx_if);
                        n_state     = ST_DONE;
                    end else begin
                        n_ridx  = '0;
                        n_qv    = 1'b0;
                        n_state = ST_RSCAN;
                    end
                end
            end
            ST_RSCAN: begin
                // address r_ridx goes out while the entry at r_chk is checked
                n_chk  = r_ridx;
                n_qv   = 1'b1;
                n_ridx = r_ridx + 1'b1;
                if (w_route_hit) begin
                    n_hop   = w_rt_q.hop;
                    n_iidx  = '0;
                    n_iqv   = 1'b0;
                    n_state = ST_ISCAN;
                end else if (r_qv && (int'(r_chk) == RT_DEPTH - 1)) begin
                    if (w_def_active) begin
                        n_state = ST_DREQ;
                    end else begin
                        n_res_found = 1'b0;
                        n_res_idx   = '0;
                        n_state     = ST_DONE;
                    end
                end
            end
            ST_DREQ: begin
                n_state = ST_DCHK;
            end
            ST_DCHK: begin
                // unwritten default entry counts as not direct, with fallback interface zero
                if (r_written[w_def_addr] && w_rt_q.direct) begin
                    n_res_found = 1'b1;
                    n_res_idx   = r_def_idx;
                    n_state     = ST_DONE;
                end else begin
                    n_hop        = w_rt_q.hop;
                    n_fallback   = r_written[w_def_addr] ? w_rt_q.iface : 3'd0;
                    n_in_default = 1'b1;
                    n_iidx       = '0;
                    n_iqv        = 1'b0;
                    n_state      = ST_ISCAN;
                end
            end
            ST_ISCAN: begin
                n_ichk = r_iidx;
                n_iqv  = 1'b1;
                n_iidx = r_iidx + 1'b1;
                if (w_if_hit) begin
                    n_res_found = 1'b1;
                    n_res_idx   = 6'(r_ichk);
                    n_state     = ST_DONE;
                end else if (w_if_fail) begin
                    if (r_in_default) begin
                        n_res_found = 1'b1;
                        n_res_idx   = 6'(r_fallback);
                        n_state     = ST_DONE;
                    end else if (w_def_active) begin
                        n_state = ST_DREQ;
                    end else begin
                        n_res_found = 1'b0;
                        n_res_idx   = '0;
                        n_state     = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid = 1'b1;
                    n_ofound = r_res_found;
                    n_oidx   = r_res_idx;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ovalid     <= 1'b0;
            r_written    <= '0;
            r_qv         <= 1'b0;
            r_iqv        <= 1'b0;
            r_in_default <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ovalid     <= n_ovalid;
            r_written    <= n_written;
            r_qv         <= n_qv;
            r_iqv        <= n_iqv;
            r_in_default <= n_in_default;
        end
        r_ridx      <= n_ridx;
        r_chk       <= n_chk;
        r_iidx      <= n_iidx;
        r_ichk      <= n_ichk;
        r_addr      <= n_addr;
        r_hop       <= n_hop;
        r_fallback  <= n_fallback;
        r_res_found <= n_res_found;
        r_res_idx   <= n_res_idx;
        r_ofound    <= n_ofound;
        r_oidx      <= n_oidx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_if_count <= '0;
            r_def_en   <= 1'b0;
            r_def_idx  <= '0;
            r_rx_if    <= '0;
            r_mcast    <= rtil_pkg::MCAST_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.data.index)
                rtil_pkg::CFG_IF_COUNT:  r_if_count <= i_cfg.data.value[3:0];
                rtil_pkg::CFG_DEF_EN:    r_def_en   <= i_cfg.data.value[0];
                rtil_pkg::CFG_DEF_INDEX: r_def_idx  <= i_cfg.data.value[5:0];
                rtil_pkg::CFG_RX_IF:     r_rx_if    <= i_cfg.data.value[2:0];
                rtil_pkg::CFG_MCAST:     r_mcast    <= i_cfg.data.value;
                default: begin
                end
            endcase
        end
    end

    // a result only enters the output register from the done state
    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == ST_DONE))
        else $error("result loaded outside done state");

    // commands other than lookups leave the sequencer idle and the output alone
    a_write_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd_acc && (i_cmd.data.command != rtil_pkg::CMD_LOOKUP))
        |=> (r_state == ST_IDLE) && !$rose(r_ovalid))
        else $error("write command did not complete in one cycle");

    // the route scan only runs before the default route is being resolved
    a_scan_not_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RSCAN) |-> !r_in_default)
        else $error("route scan entered while resolving default route");

    // an interface hit is always inside the configured interface count
    a_if_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ISCAN && w_if_hit) |=> (LW'(r_res_idx) < w_limit))
        else $error("interface hit beyond interface count");

endmodule

FILE: tb/sv/rtil_lookup_checker.sv
// checker for the route lookup unit: tracks tables and config, predicts and compares results
`timescale 1ns / 1ps
module rtil_lookup_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    rtil_cmd_if  i_cmd,
    rtil_rsp_if  i_rsp,
    rtil_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int ROUTE_N    = 64;
    localparam int IFACE_N    = 8;
    localparam int REPORT_MAX = 10;

    logic [31:0] rt_dest   [ROUTE_N];
    logic [31:0] rt_mask   [ROUTE_N];
    logic [31:0] rt_hop    [ROUTE_N];
    logic        rt_valid  [ROUTE_N];
    logic [4:0]  rt_cost   [ROUTE_N];
    logic        rt_direct [ROUTE_N];
    logic [2:0]  rt_iface  [ROUTE_N];
    logic [31:0] if_addr   [IFACE_N];
    logic [31:0] if_mask   [IFACE_N];

    logic [3:0]  if_count;
    logic        def_en;
    logic [5:0]  def_index;
    logic [2:0]  rx_if;
    logic [31:0] mcast_addr;

    rtil_pkg::t_rsp expected_q[$];

    // first interface in use whose subnet holds the hop, -1 if none
    function automatic int resolve_hop_iface(input logic [31:0] hop);
        int limit;
        int found;
        limit = (int'(if_count) > IFACE_N) ? IFACE_N : int'(if_count);
        found = -1;
        for (int k = 0; k < limit; k++) begin
            if (found < 0 && !(def_en && k == int'(def_index))
                    && (hop & if_mask[k]) == (if_addr[k] & if_mask[k]))
                found = k;
        end
        return found;
    endfunction

    function automatic rtil_pkg::t_rsp predict_lookup(input logic [31:0] dst);
        rtil_pkg::t_rsp r;
        int   hit;
        logic taken;
        r = '0;
        hit = -1;
        taken = 1'b0;
        if (dst == mcast_addr) begin
            r.route_found = 1'b1;
            r.out_index = 6'(rx_if);
        end else begin
            for (int k = 0; k < ROUTE_N; k++) begin
                if (!taken && !(def_en && k == int'(def_index)) && rt_valid[k]
                        && rt_dest[k] == (dst & rt_mask[k])
                        && rt_cost[k] != rtil_pkg::COST_UNREACHABLE) begin
                    hit = resolve_hop_iface(rt_hop[k]);
                    taken = 1'b1;
                end
            end
            if (hit >= 0) begin
                r.route_found = 1'b1;
                r.out_index = 6'(hit);
            end else if (def_en) begin
                // default entry is used even when its valid bit is clear
                r.route_found = 1'b1;
                if (rt_direct[def_index]) begin
                    r.out_index = def_index;
                end else begin
                    hit = resolve_hop_iface(rt_hop[def_index]);
                    r.out_index = (hit >= 0) ? 6'(hit) : 6'(rt_iface[def_index]);
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        rtil_pkg::t_rsp got;
        rtil_pkg::t_rsp want;
        rtil_pkg::t_cmd c;
        if (!i_rst_n) begin
            for (int k = 0; k < ROUTE_N; k++) begin
                rt_dest[k] = '0;
                rt_mask[k] = '0;
                rt_hop[k] = '0;
                rt_valid[k] = 1'b0;
                rt_cost[k] = '0;
                rt_direct[k] = 1'b0;
                rt_iface[k] = '0;
            end
            for (int k = 0; k < IFACE_N; k++) begin
                if_addr[k] = '0;
                if_mask[k] = '0;
            end
            if_count = '0;
            def_en = 1'b0;
            def_index = '0;
            rx_if = '0;
            mcast_addr = rtil_pkg::MCAST_RESET;
            expected_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.data.index)
                    rtil_pkg::CFG_IF_COUNT:  if_count = i_cfg.data.value[3:0];
                    rtil_pkg::CFG_DEF_EN:    def_en = i_cfg.data.value[0];
                    rtil_pkg::CFG_DEF_INDEX: def_index = i_cfg.data.value[5:0];
                    rtil_pkg::CFG_RX_IF:     rx_if = i_cfg.data.value[2:0];
                    rtil_pkg::CFG_MCAST:     mcast_addr = i_cfg.data.value;
                    default: ;
                endcase
            end
            // results are matched before this edge's item is predicted
            if (i_rsp.valid && i_rsp.ready) begin
                got = i_rsp.data;
                if (expected_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_MAX)
                        $display("%0t tb: lookup result with none pending: found=%0d index=%0d",
                                 $time, got.route_found, got.out_index);
                end else begin
                    want = expected_q.pop_front();
                    if (got.route_found !== want.route_found
                            || got.out_index !== want.out_index) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_MAX)
                            $display("%0t tb: exp found=%0d index=%0d, got found=%0d index=%0d",
                                     $time, want.route_found, want.out_index,
                                     got.route_found, got.out_index);
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                c = i_cmd.data;
                case (c.command)
                    rtil_pkg::CMD_LOOKUP: expected_q.push_back(predict_lookup(c.address));
                    rtil_pkg::CMD_ROUTE_WR: begin
                        rt_dest[c.entry_index] = c.address;
                        rt_mask[c.entry_index] = c.mask;
                        rt_hop[c.entry_index] = c.hop_addr;
                        rt_valid[c.entry_index] = c.entry_valid;
                        rt_cost[c.entry_index] = c.cost;
                        rt_direct[c.entry_index] = c.directly_connected;
                        rt_iface[c.entry_index] = c.route_interface;
                    end
                    rtil_pkg::CMD_IF_WR: begin
                        if (c.entry_index < 6'(IFACE_N)) begin
                            if_addr[c.entry_index[2:0]] = c.address;
                            if_mask[c.entry_index[2:0]] = c.mask;
                        end
                    end
                    default: ;
                endcase
            end
        end
        o_pending = expected_q.size();
    end

endmodule

FILE: tb/sv/tb_top.sv
// top of the route lookup unit testbench: clock, reset, stimulus, flow control and verdict
`timescale 1ns / 1ps
module tb_top;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int ROUTE_N      = 64;
    localparam int IFACE_N      = 8;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int PHASE_ITEMS  = 150;

    logic i_clk;
    logic i_rst_n;

    rtil_cmd_if cmd_ch ();
    rtil_rsp_if rsp_ch ();
    rtil_cfg_if cfg_ch ();

    int   fail_count;
    int   pending;
    logic rsp_hold_req;
    logic rsp_stall_on;
    logic send_gaps_on;

    // copy of written addresses, only used to aim lookups at routes and hops at interfaces
    logic [31:0] sh_route_dest [ROUTE_N];
    logic [31:0] sh_route_mask [ROUTE_N];
    logic [31:0] sh_if_addr    [IFACE_N];
    logic [31:0] sh_if_mask    [IFACE_N];
    logic [31:0] cur_mcast;
    logic [5:0]  cur_def_index;

    route_table_interface_lookup_unit #(
        .ROUTE_ENTRIES     (ROUTE_N),
        .INTERFACE_ENTRIES (IFACE_N)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    rtil_lookup_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_rsp        (rsp_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 3);
        if (roll < 90)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // mostly inside a few small subnets so routes, hops and interfaces overlap
    function automatic logic [31:0] rand_addr();
        if ($urandom_range(0, 9) < 7)
            return {8'd10, 6'd0, 2'($urandom_range(0, 3)), 6'd0, 2'($urandom_range(0, 3)),
                    8'($urandom)};
        return $urandom;
    endfunction

    function automatic logic [31:0] rand_mask();
        int len;
        if ($urandom_range(0, 19) == 0)
            return $urandom;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32) : $urandom_range(14, 26);
        return 32'hFFFF_FFFF << (32 - len);
    endfunction

    function automatic rtil_pkg::t_cmd noise_item();
        rtil_pkg::t_cmd c;
        c.command = 2'($urandom);
        c.entry_index = 6'($urandom);
        c.address = $urandom;
        c.mask = $urandom;
        c.hop_addr = $urandom;
        c.cost = 5'($urandom);
        c.directly_connected = 1'($urandom);
        c.route_interface = 3'($urandom);
        c.entry_valid = 1'($urandom);
        return c;
    endfunction

    task automatic send_item(input rtil_pkg::t_cmd c);
        int gap;
        gap = (!send_gaps_on || $urandom_range(0, 9) < 4) ? 0 : gap_len();
        cmd_ch.valid <= 1'b1;
        cmd_ch.data <= c;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_route(input logic [5:0] idx);
        rtil_pkg::t_cmd c;
        int   roll;
        int   k;
        c = noise_item();
        c.command = rtil_pkg::CMD_ROUTE_WR;
        c.entry_index = idx;
        c.mask = rand_mask();
        c.address = ($urandom_range(0, 4) == 0) ? rand_addr() : (rand_addr() & c.mask);
        if ($urandom_range(0, 4) < 3) begin
            k = $urandom_range(0, IFACE_N - 1);
            c.hop_addr = (sh_if_addr[k] & sh_if_mask[k]) | ($urandom & ~sh_if_mask[k]);
        end else begin
            c.hop_addr = rand_addr();
        end
        roll = $urandom_range(0, 19);
        if (roll == 0)
            c.cost = 5'd0;
        else if (roll < 3)
            c.cost = rtil_pkg::COST_UNREACHABLE;
        else if (roll == 3)
            c.cost = 5'($urandom_range(17, 31));
        else
            c.cost = 5'($urandom_range(1, 15));
        c.entry_valid = ($urandom_range(0, 7) != 0);
        sh_route_dest[idx] = c.address;
        sh_route_mask[idx] = c.mask;
        send_item(c);
    endtask

    task automatic send_iface(input logic [5:0] idx);
        rtil_pkg::t_cmd c;
        c = noise_item();
        c.command = rtil_pkg::CMD_IF_WR;
        c.entry_index = idx;
        c.address = rand_addr();
        c.mask = rand_mask();
        if (idx < 6'(IFACE_N)) begin
            sh_if_addr[idx[2:0]] = c.address;
            sh_if_mask[idx[2:0]] = c.mask;
        end
        send_item(c);
    endtask

    task automatic send_lookup();
        rtil_pkg::t_cmd c;
        int   roll;
        int   k;
        c = noise_item();
        c.command = rtil_pkg::CMD_LOOKUP;
        roll = $urandom_range(0, 19);
        if (roll < 12) begin
            k = $urandom_range(0, ROUTE_N - 1);
            c.address = (sh_route_dest[k] & sh_route_mask[k]) | ($urandom & ~sh_route_mask[k]);
        end else if (roll < 14) begin
            c.address = cur_mcast;
        end else if (roll == 14) begin
            c.address = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
        end else begin
            c.address = rand_addr();
        end
        send_item(c);
    endtask

    task automatic write_cfg(input rtil_pkg::t_cfg_index idx, input logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= {idx, value};
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // writes give no result, so let a possible last lookup finish after the queue drains
    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [3:0] count, input logic en, input logic [5:0] didx,
                             input logic [2:0] rx, input logic [31:0] mcast,
                             input logic hold, input logic pause);
        int   roll;
        rtil_pkg::t_cmd c;
        wait_idle();
        write_cfg(rtil_pkg::CFG_IF_COUNT, {28'd0, count});
        write_cfg(rtil_pkg::CFG_DEF_EN, {31'd0, en});
        write_cfg(rtil_pkg::CFG_DEF_INDEX, {26'd0, didx});
        write_cfg(rtil_pkg::CFG_RX_IF, {29'd0, rx});
        write_cfg(rtil_pkg::CFG_MCAST, mcast);
        cur_mcast = mcast;
        cur_def_index = didx;
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (hold && k == 10)
                rsp_hold_req = 1'b1;
            if (pause && k == PHASE_ITEMS / 2)
                wait_idle();
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                send_lookup();
            end else if (roll < 78) begin
                send_route((roll < 62) ? cur_def_index : 6'($urandom));
            end else if (roll < 90) begin
                send_iface((roll < 88) ? 6'($urandom_range(0, IFACE_N - 1))
                                       : 6'($urandom_range(IFACE_N, 63)));
            end else if (roll < 94) begin
                c = noise_item();
                c.command = CMD_UNUSED;
                send_item(c);
            end else begin
                send_lookup();
            end
        end
    endtask

    // result side flow control
    initial begin
        int n;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (rsp_hold_req) begin
                rsp_hold_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                n = HOLD_CYCLES;
            end else if (!rsp_stall_on || $urandom_range(0, 2) != 0) begin
                rsp_ch.ready <= 1'b1;
                n = $urandom_range(1, 40);
            end else begin
                rsp_ch.ready <= 1'b0;
                n = gap_len();
            end
            repeat (n) @(posedge i_clk);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        rtil_pkg::t_cmd c;
        i_rst_n <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.data <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= '0;
        rsp_hold_req = 1'b0;
        rsp_stall_on = 1'b1;
        send_gaps_on = 1'b1;
        cur_mcast = rtil_pkg::MCAST_RESET;
        cur_def_index = '0;
        for (int k = 0; k < ROUTE_N; k++) begin
            sh_route_dest[k] = '0;
            sh_route_mask[k] = '0;
        end
        for (int k = 0; k < IFACE_N; k++) begin
            sh_if_addr[k] = '0;
            sh_if_mask[k] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty tables, reset config: multicast default and address extremes
        c = noise_item();
        c.command = rtil_pkg::CMD_LOOKUP;
        c.address = rtil_pkg::MCAST_RESET;
        send_item(c);
        c.address = 32'h0;
        send_item(c);
        c.address = 32'hFFFF_FFFF;
        send_item(c);
        // top route with every field at its maximum, cost above sixteen stays reachable
        c = '1;
        c.command = rtil_pkg::CMD_ROUTE_WR;
        send_item(c);
        c = '0;
        c.command = rtil_pkg::CMD_ROUTE_WR;
        send_item(c);
        // interface index past the table is dropped
        c = '1;
        c.command = rtil_pkg::CMD_IF_WR;
        send_item(c);
        c = '1;
        c.command = CMD_UNUSED;
        send_item(c);
        c = '0;
        c.command = CMD_UNUSED;
        send_item(c);
        c = '1;
        c.command = rtil_pkg::CMD_LOOKUP;
        send_item(c);
        c = '0;
        c.command = rtil_pkg::CMD_LOOKUP;
        send_item(c);

        // fill both tables before any interface count or default route is enabled
        for (int k = 0; k < IFACE_N; k++)
            send_iface(6'(k));
        for (int k = 0; k < ROUTE_N; k++)
            send_route(6'(k));

        run_phase(4'd8, 1'b0, 6'd0, 3'd5, rtil_pkg::MCAST_RESET, 1'b0, 1'b0);
        run_phase(4'd15, 1'b1, 6'd0, 3'd7, 32'h0, 1'b1, 1'b0);
        rsp_stall_on = 1'b0;
        send_gaps_on = 1'b0;
        run_phase(4'd3, 1'b1, 6'd63, 3'd0, 32'hFFFF_FFFF, 1'b0, 1'b0);
        rsp_stall_on = 1'b1;
        send_gaps_on = 1'b1;
        run_phase(4'd0, 1'b1, 6'd5, 3'd2, $urandom, 1'b0, 1'b1);
        run_phase(4'd8, 1'b1, 6'd2, 3'd1, rand_addr(), 1'b1, 1'b1);
        run_phase(4'd5, 1'b0, 6'd63, 3'd3, rtil_pkg::MCAST_RESET, 1'b0, 1'b0);
        run_phase(4'd8, 1'b1, 6'($urandom), 3'($urandom), rand_addr(), 1'b0, 1'b1);

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/rtil_pkg.sv
hw/rtl/rtil_if.sv
hw/rtl/rtil_ram.sv
hw/rtl/route_table_interface_lookup_unit.sv
tb/sv/rtil_lookup_checker.sv
tb/sv/tb_top.sv
